FILE: design/lacpg_pkg.sv
// shared types, codes and constants for the line, arc and circle point generator
`default_nettype none
package lacpg_pkg;

    // item actions
    typedef enum logic [1:0] {
        ACT_LINE   = 2'd0,
        ACT_ARC    = 2'd1,
        ACT_CIRCLE = 2'd2,
        ACT_STEP   = 2'd3
    } t_action;

    // configuration register indexes
    localparam logic CFG_ANGLE_STEP  = 1'b0;
    localparam logic CFG_LINE_POINTS = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_DIV,
        S_LINE_DX,
        S_LINE_DY,
        S_ARC_DIV,
        S_ANGLE,
        S_ZMUL,
        S_ZDIV,
        S_CORDIC,
        S_MUL,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] x_a;
        logic signed [31:0] y_a;
        logic signed [31:0] x_b;
        logic signed [31:0] y_b;
        logic [30:0]        radius;
        logic [16:0]        angle_begin;
        logic [16:0]        angle_finish;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               last_point;
    } t_out_item;

    localparam logic [16:0] ANGLE_STEP_RST  = 17'd128;
    localparam logic [7:0]  LINE_POINTS_RST = 8'd10;
    localparam logic [16:0] FULL_TURN       = 17'd92160;
    localparam logic [17:0] TWO_TURNS       = 18'd184320;
    localparam logic [17:0] QUARTER_TURN    = 18'd23040;
    localparam logic [17:0] HALF_TURN       = 18'd46080;
    localparam logic [17:0] THREE_QUARTERS  = 18'd69120;
    // radians * 2^30 per 1/256 degree in 11520ths: whole part and leftover
    localparam logic [16:0] RAD_WHOLE       = 17'd73204;
    localparam logic [12:0] RAD_FRAC        = 13'd4777;
    // floor(v / 45) = (v * DIV45_RECIP) >> 25 for v below 2^19
    localparam logic [19:0] DIV45_RECIP     = 20'd745655;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // divider dividend width
    localparam int DIV_W = 48;

    // arctangent of 2^-i, scaled by 2^30
    function automatic logic signed [33:0] atan_at(input logic [4:0] idx);
        logic signed [33:0] v;
        unique case (idx)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043836;
            5'd3:  v = 34'sd133525158;
            5'd4:  v = 34'sd67021686;
            5'd5:  v = 34'sd33543515;
            5'd6:  v = 34'sd16775850;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194282;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048575;
            5'd11: v = 34'sd524287;
            5'd12: v = 34'sd262143;
            5'd13: v = 34'sd131071;
            5'd14: v = 34'sd65535;
            5'd15: v = 34'sd32767;
            5'd16: v = 34'sd16383;
            5'd17: v = 34'sd8191;
            5'd18: v = 34'sd4095;
            5'd19: v = 34'sd2047;
            5'd20: v = 34'sd1023;
            5'd21: v = 34'sd511;
            5'd22: v = 34'sd255;
            5'd23: v = 34'sd127;
            5'd24: v = 34'sd63;
            5'd25: v = 34'sd31;
            5'd26: v = 34'sd15;
            5'd27: v = 34'sd7;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -37'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/line_arc_circle_point_generator.sv
// line, arc and circle point generator with one shared shift-subtract divider
// steps: a line load only registers the item; an arc or circle load runs one divide
// a line point runs two divides; an arc point runs a divide, reduction, radian scale,
// rotation and 4 multiplies; the last point of an item skips the divides
// one item at a time, input stalled until it is done
// reset: synchronous active low, registers to defaults, nothing pending
`default_nettype none
module line_arc_circle_point_generator #(
    parameter int CORDIC_ITERS = 24
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire lacpg_pkg::t_in_item  i_in_data,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output lacpg_pkg::t_out_item      o_out_data,
    input  wire                       i_cfg_we,
    input  wire                       i_cfg_idx,
    input  wire  [16:0]               i_cfg_wdata
);
    import lacpg_pkg::*;

    localparam int IT_W = $clog2(CORDIC_ITERS + 1);

    t_state r_state, n_state;

    // configuration and primitive state
    logic [16:0] r_angle_step;
    logic [7:0]  r_line_points;
    logic [1:0]  r_kind;
    logic signed [31:0] r_base_x, r_base_y, r_end_x, r_end_y;
    logic [30:0] r_radius;
    logic [16:0] r_start, r_final, r_span, r_total, r_index;

    // working registers
    logic              r_last;
    logic              r_neg;
    logic signed [31:0] r_px, r_py;
    logic [17:0]       r_ang;
    logic [1:0]        r_quad;
    logic [14:0]       r_rem15;
    logic [31:0]       r_zhi;
    logic [18:0]       r_zv;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic [IT_W-1:0]   r_it;
    logic signed [33:0] r_c, r_s;
    logic signed [65:0] r_acc;
    logic [2:0]        r_mk;
    t_out_item         r_out;
    logic              r_ovalid;

    // shared divider
    logic [DIV_W-1:0] r_dquo;
    logic [16:0]      r_drem, r_ddvs;
    logic [5:0]       r_dcnt;
    logic [17:0]      div_trial;
    logic             div_ge;
    logic             div_done;

    assign div_trial = {r_drem, r_dquo[DIV_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_ddvs};
    assign div_done  = (r_dcnt == 6'd0);

    // accept and step decode
    logic in_acc, pending, step_last;
    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign pending   = r_index < r_total;
    assign step_last = (r_index + 17'd1) == r_total;

    // load-time span
    logic [16:0] ld_start, ld_final, ld_span, ld_stp;
    always_comb begin
        if (t_action'(i_in_data.action) == ACT_ARC) begin
            ld_start = i_in_data.angle_begin;
            ld_final = i_in_data.angle_finish;
        end else begin
            ld_start = 17'd0;
            ld_final = FULL_TURN;
        end
        ld_span = (ld_final >= ld_start) ? ld_final - ld_start : ld_start - ld_final;
        ld_stp  = (r_angle_step == 17'd0) ? 17'd1 : r_angle_step;
    end

    // line offsets i*(end-base), the index has already advanced for y
    logic signed [32:0] ln_dx, ln_dy;
    logic signed [41:0] ln_px, ln_py;
    logic [41:0]        ln_ax, ln_ay;
    logic [32:0]        ln_q;
    logic signed [32:0] ln_off;
    always_comb begin
        ln_dx  = 33'(r_end_x) - 33'(r_base_x);
        ln_dy  = 33'(r_end_y) - 33'(r_base_y);
        ln_px  = $signed({1'b0, r_index[7:0]}) * ln_dx;
        ln_py  = $signed({1'b0, r_index[7:0] - 8'd1}) * ln_dy;
        ln_ax  = ln_px[41] ? 42'(-ln_px) : 42'(ln_px);
        ln_ay  = ln_py[41] ? 42'(-ln_py) : 42'(ln_py);
        ln_q   = r_dquo[32:0];
        ln_off = r_neg ? -$signed(ln_q) : $signed(ln_q);
    end

    // angle reduction and quadrant split
    logic [17:0] an_a, an_r;
    logic [1:0]  an_q;
    always_comb begin
        if (r_ang >= TWO_TURNS) begin
            an_a = r_ang - TWO_TURNS;
        end else if (r_ang >= {1'b0, FULL_TURN}) begin
            an_a = r_ang - {1'b0, FULL_TURN};
        end else begin
            an_a = r_ang;
        end
        priority if (an_a >= THREE_QUARTERS) begin
            an_q = 2'd3; an_r = an_a - THREE_QUARTERS;
        end else if (an_a >= HALF_TURN) begin
            an_q = 2'd2; an_r = an_a - HALF_TURN;
        end else if (an_a >= QUARTER_TURN) begin
            an_q = 2'd1; an_r = an_a - QUARTER_TURN;
        end else begin
            an_q = 2'd0; an_r = an_a;
        end
    end

    // leftover radian part divided by 45 through a reciprocal multiply
    logic [38:0] zr_prod;
    logic [13:0] zr_q;
    always_comb begin
        zr_prod = 39'(r_zv) * 39'(DIV45_RECIP);
        zr_q    = zr_prod[38:25];
    end

    // cordic micro-rotation
    logic signed [33:0] cr_dx, cr_dy, cr_at;
    logic               cr_done;
    always_comb begin
        cr_dx   = r_cy >>> r_it;
        cr_dy   = r_cx >>> r_it;
        cr_at   = atan_at(r_it[4:0]);
        cr_done = (r_it == IT_W'(CORDIC_ITERS));
    end

    // quadrant mapping
    logic signed [33:0] mp_c, mp_s;
    always_comb begin
        unique case (r_quad)
            2'd0: begin mp_c = r_cx;  mp_s = r_cy;  end
            2'd1: begin mp_c = -r_cy; mp_s = r_cx;  end
            2'd2: begin mp_c = -r_cx; mp_s = -r_cy; end
            2'd3: begin mp_c = r_cy;  mp_s = -r_cx; end
        endcase
    end

    // partial product multiplier and rounding
    logic signed [33:0] mu_a;
    logic signed [16:0] mu_b;
    logic signed [50:0] mu_p;
    logic signed [65:0] mu_pp;
    logic signed [65:0] rd_v;
    logic signed [36:0] rd_sum;
    always_comb begin
        mu_a  = r_mk[1] ? r_s : r_c;
        mu_b  = r_mk[0] ? $signed({2'b00, r_radius[30:16]}) : $signed({1'b0, r_radius[15:0]});
        mu_p  = mu_a * mu_b;
        mu_pp = r_mk[0] ? (66'(mu_p) <<< 16) : 66'(mu_p);
        rd_v  = (r_acc + (66'sd1 <<< 29)) >>> 30;
        rd_sum = 37'($signed(rd_v[35:0])) + 37'((r_mk == 3'd2) ? r_base_x : r_base_y);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_action'(i_in_data.action))
                        ACT_LINE: n_state = S_IDLE;
                        ACT_ARC, ACT_CIRCLE: n_state = S_LOAD_DIV;
                        ACT_STEP: begin
                            if (!pending) begin
                                n_state = S_IDLE;
                            end else if (t_action'(r_kind) == ACT_LINE) begin
                                n_state = step_last ? S_FIN : S_LINE_DX;
                            end else begin
                                n_state = step_last ? S_ANGLE : S_ARC_DIV;
                            end
                        end
                    endcase
                end
            end
            S_LOAD_DIV: if (div_done) n_state = S_IDLE;
            S_LINE_DX:  if (div_done) n_state = S_LINE_DY;
            S_LINE_DY:  if (div_done) n_state = S_FIN;
            S_ARC_DIV:  if (div_done) n_state = S_ANGLE;
            S_ANGLE:    n_state = S_ZMUL;
            S_ZMUL:     n_state = S_ZDIV;
            S_ZDIV:     n_state = S_CORDIC;
            S_CORDIC:   if (cr_done) n_state = S_MUL;
            S_MUL:      if (r_mk == 3'd4) n_state = S_FIN;
            S_FIN:      if (!r_ovalid || !i_out_stall) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = r_ovalid;
        o_out_data  = r_out;
    end

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ovalid      <= 1'b0;
            r_angle_step  <= ANGLE_STEP_RST;
            r_line_points <= LINE_POINTS_RST;
            r_kind        <= 2'd0;
            r_base_x      <= '0;
            r_base_y      <= '0;
            r_end_x       <= '0;
            r_end_y       <= '0;
            r_radius      <= '0;
            r_start       <= '0;
            r_final       <= '0;
            r_span        <= '0;
            r_total       <= '0;
            r_index       <= '0;
            r_dcnt        <= '0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ANGLE_STEP:  r_angle_step  <= i_cfg_wdata;
                    CFG_LINE_POINTS: r_line_points <= i_cfg_wdata[7:0];
                endcase
            end

            // output beat taken
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_FIN && (!r_ovalid || !i_out_stall)) begin
                r_ovalid <= 1'b1;
            end

            // divider step
            if (!div_done) begin
                r_dcnt <= r_dcnt - 6'd1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (t_action'(i_in_data.action) != ACT_STEP) begin
                            r_base_x <= i_in_data.x_a;
                            r_base_y <= i_in_data.y_a;
                            r_index  <= '0;
                            r_kind   <= i_in_data.action;
                            if (t_action'(i_in_data.action) == ACT_LINE) begin
                                r_end_x <= i_in_data.x_b;
                                r_end_y <= i_in_data.y_b;
                                r_total <= (r_line_points == 8'd0) ? 17'd1
                                                                   : 17'(r_line_points);
                            end else begin
                                r_radius <= i_in_data.radius;
                                r_start  <= ld_start;
                                r_final  <= ld_final;
                                r_span   <= ld_span;
                                r_dcnt   <= 6'(DIV_W);
                            end
                        end else if (pending) begin
                            r_index <= r_index + 17'd1;
                            if (t_action'(r_kind) == ACT_LINE) begin
                                if (!step_last) r_dcnt <= 6'(DIV_W);
                            end else if (!step_last) begin
                                r_dcnt <= 6'(DIV_W);
                            end
                        end
                    end
                end
                S_LINE_DX: if (div_done) r_dcnt <= 6'(DIV_W);
                S_LOAD_DIV: if (div_done) r_total <= r_dquo[16:0];
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!div_done) begin
            r_drem <= div_ge ? 17'(div_trial - {1'b0, r_ddvs}) : div_trial[16:0];
            r_dquo <= {r_dquo[DIV_W-2:0], div_ge};
        end
        unique case (r_state)
            S_IDLE: begin
                r_last <= step_last;
                r_drem <= '0;
                if (t_action'(i_in_data.action) != ACT_STEP) begin
                    r_dquo <= DIV_W'(ld_span);
                    r_ddvs <= ld_stp;
                end else if (t_action'(r_kind) == ACT_LINE) begin
                    r_px   <= r_end_x;
                    r_py   <= r_end_y;
                    r_neg  <= ln_px[41];
                    r_dquo <= DIV_W'(ln_ax);
                    r_ddvs <= r_total;
                end else begin
                    r_ang  <= {1'b0, r_final};
                    r_dquo <= DIV_W'(r_index) * DIV_W'(r_span);
                    r_ddvs <= r_total;
                end
            end
            S_LINE_DX: begin
                if (div_done) begin
                    r_px   <= 32'(33'(r_base_x) + ln_off);
                    r_neg  <= ln_py[41];
                    r_dquo <= DIV_W'(ln_ay);
                    r_drem <= '0;
                end
            end
            S_LINE_DY: begin
                if (div_done) r_py <= 32'(33'(r_base_y) + ln_off);
            end
            S_ARC_DIV: begin
                if (div_done) r_ang <= {1'b0, r_start} + r_dquo[17:0];
            end
            S_ANGLE: begin
                r_quad  <= an_q;
                r_rem15 <= an_r[14:0];
            end
            S_ZMUL: begin
                r_zhi <= 32'(r_rem15) * 32'(RAD_WHOLE);
                r_zv  <= 19'((27'(r_rem15) * 27'(RAD_FRAC)) >> 8);
            end
            S_ZDIV: begin
                r_cz <= $signed(34'(r_zhi) + 34'(zr_q));
                r_cx <= CORDIC_GAIN;
                r_cy <= '0;
                r_it <= '0;
            end
            S_CORDIC: begin
                if (!cr_done) begin
                    if (!r_cz[33]) begin
                        r_cx <= r_cx - cr_dx;
                        r_cy <= r_cy + cr_dy;
                        r_cz <= r_cz - cr_at;
                    end else begin
                        r_cx <= r_cx + cr_dx;
                        r_cy <= r_cy - cr_dy;
                        r_cz <= r_cz + cr_at;
                    end
                    r_it <= r_it + IT_W'(1);
                end else begin
                    r_c  <= mp_c;
                    r_s  <= mp_s;
                    r_mk <= '0;
                end
            end
            S_MUL: begin
                r_mk <= r_mk + 3'd1;
                unique case (r_mk)
                    3'd0, 3'd1: r_acc <= (r_mk == 3'd0) ? mu_pp : r_acc + mu_pp;
                    3'd2: begin
                        r_px  <= sat32(rd_sum);
                        r_acc <= mu_pp;
                    end
                    3'd3: r_acc <= r_acc + mu_pp;
                    default: r_py <= sat32(rd_sum);
                endcase
            end
            S_FIN: begin
                if (!r_ovalid || !i_out_stall) begin
                    r_out.point_x    <= r_px;
                    r_out.point_y    <= r_py;
                    r_out.last_point <= r_last;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: design/lacpg_checker.sv
// port-level checks for the point generator, bound to the top level
`default_nettype none
module lacpg_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       o_in_stall,
    input wire                       o_out_valid,
    input wire                       i_out_stall,
    input wire lacpg_pkg::t_out_item o_out_data
);
    import lacpg_pkg::*;

    // reset leaves no result beat pending
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // reset leaves the input side open
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

endmodule

bind line_arc_circle_point_generator lacpg_checker u_lacpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

FILE: test/line_arc_circle_point_generator_check.sv
// checker for the point generator: watches the channels, predicts points and compares
`timescale 1ns / 1ps
module line_arc_circle_point_generator_check (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_stall,
    input  lacpg_pkg::t_in_item  i_in_data,
    input  wire                  i_out_valid,
    input  wire                  i_out_stall,
    input  lacpg_pkg::t_out_item i_out_data,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_idx,
    input  wire  [16:0]          i_cfg_wdata,
    output int                   o_errors,
    output int                   o_pending
);
    import lacpg_pkg::*;

    localparam int ROTATIONS = 24;

    // arctangent of 2^-i scaled by 2^30
    localparam longint ARCTAN [0:23] = '{
        843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127
    };

    // mirrored block state
    int unsigned step_angle, points_per_line;
    t_action     shape;
    longint      org_x, org_y, dst_x, dst_y, rad;
    int unsigned ang_lo, ang_hi, span, n_points, n_done;

    t_out_item   point_fifo [$];

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // rotate to a quarter-turn remainder, then fold the quadrant back in
    function automatic void cos_sin(input int unsigned angle, output longint c,
                                    output longint s);
        int unsigned a, q, r;
        longint x, y, z, dx, dy;
        a = angle % 92160;
        q = a / 23040;
        r = a % 23040;
        x = 652032874;
        y = 0;
        z = (longint'(r) * 843314857) / 11520;
        for (int i = 0; i < ROTATIONS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARCTAN[i];
            end else begin
                x += dx; y -= dy; z += ARCTAN[i];
            end
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // apply one item, return 1 with the point when a point comes out
    function automatic bit next_point(input t_in_item it, output t_out_item pt);
        int unsigned ang;
        bit          fin;
        longint      px, py, c, s;
        pt = '0;
        if (t_action'(it.action) != ACT_STEP) begin
            org_x = it.x_a;
            org_y = it.y_a;
            n_done = 0;
            shape = t_action'(it.action);
            if (shape == ACT_LINE) begin
                dst_x = it.x_b;
                dst_y = it.y_b;
                n_points = points_per_line ? points_per_line : 1;
            end else begin
                rad = it.radius;
                if (shape == ACT_ARC) begin
                    ang_lo = it.angle_begin;
                    ang_hi = it.angle_finish;
                end else begin
                    ang_lo = 0;
                    ang_hi = 92160;
                end
                span = ang_hi >= ang_lo ? ang_hi - ang_lo : ang_lo - ang_hi;
                n_points = span / (step_angle ? step_angle : 1);
            end
            return 0;
        end
        if (n_done >= n_points) return 0;
        fin = (n_done + 1 == n_points);
        if (shape == ACT_LINE) begin
            if (fin) begin
                px = dst_x; py = dst_y;
            end else begin
                px = org_x + (longint'(n_done) * (dst_x - org_x)) / longint'(n_points);
                py = org_y + (longint'(n_done) * (dst_y - org_y)) / longint'(n_points);
            end
        end else begin
            if (fin) ang = ang_hi;
            else ang = ang_lo + int'((longint'(n_done) * span) / n_points);
            cos_sin(ang, c, s);
            px = org_x + ((rad * c + (64'sd1 <<< 29)) >>> 30);
            py = org_y + ((rad * s + (64'sd1 <<< 29)) >>> 30);
        end
        pt.point_x = clamp32(px);
        pt.point_y = clamp32(py);
        pt.last_point = fin;
        n_done++;
        return 1;
    endfunction

    // track config writes, input beats and output beats
    always @(posedge i_clk) begin
        t_out_item want, got;
        if (!i_rst_n) begin
            step_angle = ANGLE_STEP_RST;
            points_per_line = LINE_POINTS_RST;
            shape = ACT_LINE;
            org_x = 0; org_y = 0; dst_x = 0; dst_y = 0; rad = 0;
            ang_lo = 0; ang_hi = 0; span = 0; n_points = 0; n_done = 0;
            point_fifo.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ANGLE_STEP) step_angle = i_cfg_wdata;
                else points_per_line = i_cfg_wdata[7:0];
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (point_fifo.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected point beat %h", $realtime, got);
                end else begin
                    want = point_fifo.pop_front();
                    if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
                        got.last_point !== want.last_point) begin
                        o_errors++;
                        $display("%0t: point mismatch expected x=%0d y=%0d last=%0b got x=%0d y=%0d last=%0b",
                                 $realtime, want.point_x, want.point_y, want.last_point,
                                 got.point_x, got.point_y, got.last_point);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (next_point(i_in_data, want)) point_fifo.push_back(want);
            end
        end
        o_pending = point_fifo.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

endmodule

FILE: test/line_arc_circle_point_generator_test.sv
// testbench top for the point generator: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module line_arc_circle_point_generator_test;
    import lacpg_pkg::*;

    localparam int QUIET_LIMIT = 8000;
    localparam int SETTLE = 300;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_data;
    logic       cfg_we = 1'b0;
    logic       cfg_idx = CFG_ANGLE_STEP;
    logic [16:0] cfg_wdata = '0;
    int         errors, pending;
    int         send_idle = 0, recv_idle = 0;
    int         quiet = 0;
    int unsigned cur_step = 128;

    always #6 i_clk = ~i_clk;

    line_arc_circle_point_generator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata)
    );

    line_arc_circle_point_generator_check i_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver back-pressure
    always @(negedge i_clk) begin
        out_stall <= ($urandom % 100) < recv_idle;
    end

    // watchdog on cycles with no beat of any kind
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !i_rst_n) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("line_arc_circle_point_generator test failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // one input beat, entered and left at a falling edge
    task automatic send_beat(input t_in_item it);
        if (($urandom % 100) < send_idle) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    // register write while the block is idle
    task automatic write_reg(input logic idx, input logic [16:0] val);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        if (idx == CFG_ANGLE_STEP) cur_step = val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom % 5)
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom_range(0, 2097152) - 1048576;
        endcase
    endfunction

    function automatic t_in_item shape_item(input t_action act);
        t_in_item it;
        int unsigned b, d;
        it.action = act;
        it.x_a = pick_coord();
        it.y_a = pick_coord();
        it.x_b = pick_coord();
        it.y_b = pick_coord();
        case ($urandom % 4)
            0: it.radius = $urandom;
            1: it.radius = 31'h7fffffff;
            default: it.radius = $urandom_range(0, 1048576);
        endcase
        b = $urandom_range(0, 92160);
        d = $urandom_range(0, 12) * (cur_step > 8000 ? 8000 : cur_step) + $urandom_range(0, 200);
        if ($urandom % 8 == 0) d = $urandom_range(0, 92160);
        if ($urandom_range(0, 1)) it.angle_finish = (b + d > 92160) ? 92160 : b + d;
        else it.angle_finish = (b < d) ? 0 : b - d;
        it.angle_begin = b;
        return it;
    endfunction

    function automatic t_in_item step_item();
        t_in_item it;
        it = shape_item(ACT_STEP);
        return it;
    endfunction

    task automatic run_steps(input int n);
        repeat (n) send_beat(step_item());
    endtask

    // load-then-step sequences with some stray steps mixed in
    task automatic random_part(input int n_items);
        int sent, n;
        t_in_item it;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom % 10 == 0) begin
                send_beat(step_item());
                sent++;
            end else begin
                it = shape_item(t_action'($urandom_range(0, 2)));
                send_beat(it);
                n = ($urandom % 6 == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
                run_steps(n);
                sent += n + 1;
            end
            if (sent > n_items / 2 && sent <= n_items / 2 + 10) begin
                in_valid <= 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
        end
    endtask

    initial begin
        t_in_item it;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: step with nothing pending, line extremes, arc cases, circle
        send_beat(step_item());
        it = shape_item(ACT_LINE);
        it.x_a = 32'h80000000; it.y_a = 32'h7fffffff;
        it.x_b = 32'h7fffffff; it.y_b = 32'h80000000;
        send_beat(it);
        run_steps(11);
        write_reg(CFG_LINE_POINTS, 17'd3);
        it = shape_item(ACT_LINE);
        it.x_b = it.x_a; it.y_b = it.y_a;
        send_beat(it);
        run_steps(2);
        // span shorter than one step gives no points
        it = shape_item(ACT_ARC);
        it.angle_begin = 17'd1000; it.angle_finish = 17'd1100;
        send_beat(it);
        run_steps(1);
        // descending arc reaching across the quadrants
        it.angle_begin = 17'd92160; it.angle_finish = 17'd91520;
        it.x_a = 32'h7fffff00; it.radius = 31'h7fffffff;
        send_beat(it);
        run_steps(3);
        write_reg(CFG_ANGLE_STEP, 17'd23040);
        it = shape_item(ACT_CIRCLE);
        it.radius = 31'd65536;
        send_beat(it);
        run_steps(5);

        // phases with different register settings and idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_ANGLE_STEP, 17'd128);
                    write_reg(CFG_LINE_POINTS, 17'd10);
                    send_idle = 27; recv_idle = 58;
                end
                1: begin
                    write_reg(CFG_ANGLE_STEP, 17'd1);
                    write_reg(CFG_LINE_POINTS, 17'd255);
                    send_idle = 58; recv_idle = 27;
                end
                2: begin
                    write_reg(CFG_ANGLE_STEP, 17'd92160);
                    write_reg(CFG_LINE_POINTS, 17'd1);
                    send_idle = 0; recv_idle = 0;
                end
                default: begin
                    write_reg(CFG_ANGLE_STEP, $urandom_range(0, 1) ? 17'd0 : 17'd1000);
                    write_reg(CFG_LINE_POINTS, $urandom_range(0, 1) ? 17'd0 : 17'd7);
                end
            endcase
            random_part(370);
        end

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("line_arc_circle_point_generator test passed");
        end else begin
            $display("line_arc_circle_point_generator test failed");
        end
        $finish;
    end

endmodule
